/* src/adc_peak_to_peak_histogram_monitor_unit_macros.svh */
// Assertion helpers for the monitor unit
`ifndef ADC_PEAK_TO_PEAK_HISTOGRAM_MONITOR_UNIT_MACROS_SVH
`define ADC_PEAK_TO_PEAK_HISTOGRAM_MONITOR_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset
`define APPM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition is followed by another one in the next cycle
`define APPM_ASSERT_STEP(name, pre, post, msg) \
  `APPM_ASSERT(name, (pre) |=> (post), msg)

`endif

/* src/appm_pkg.sv */
`default_nettype none

package appm_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_SCAN,
    ST_DRAIN,
    ST_LOAD
  } appm_state_e;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned BUSY_W   = 5;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 56;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_REPORT_MIN_SETS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_THRESHOLD   = 8'd1;

  localparam logic [SAMPLE_W-1:0] ADC_FULL  = 12'd4095;
  localparam logic [CNT_W-1:0]    CNT_MAX   = 16'hFFFF;
  localparam logic [BUSY_W-1:0]   BUSY_MAX  = 5'd31;
  localparam logic [CNT_W-1:0]    MIN_SETS_RST  = 16'd200;
  localparam logic [CNT_W-1:0]    THRESHOLD_RST = 16'd5;

endpackage

`default_nettype wire

/* src/adc_peak_to_peak_histogram_monitor_unit.sv */
// ADC peak-to-peak and histogram monitor.
// Input words on s_axis: tuser = 0 carries a sample set (one 12-bit sample per
// channel), tuser = 1 is a report tick. Each sample set updates per-channel
// max/min, one saturating histogram bin per channel (sample*BINS/4095, clamped
// to the last bin) and a saturating set counter. A report tick with more than
// report_min_sets sets produces one output word per channel, channel 0 first,
// tlast on the final channel, then clears the statistics; otherwise it is
// dropped without effect.
// A sample set does a histogram read, then increment and write back, per
// channel, through one memory port pair. A report tick reads one bin per cycle,
// with each bin zeroed as it is read. s_axis_tready is high only between items.
// Results wait in an output register; a stalled m_axis holds the walk, and
// s_axis_tready with it, when the next channel line is ready to load. Words are
// taken again once the last line is loaded, even while it still waits.
// Reset: registers go to their reset values and the histogram memory is
// cleared while s_axis_tready stays low.
// Configuration writes on cfg_* are always accepted; indexes above 1 are dropped.

`default_nettype none

`include "adc_peak_to_peak_histogram_monitor_unit_macros.svh"

module adc_peak_to_peak_histogram_monitor_unit
  import appm_pkg::*;
#(
  parameter int unsigned CHANNELS = 2,
  parameter int unsigned BINS     = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  // [11:0] sample_first, [23:12] sample_second
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] command
  input  wire logic                   s_axis_tuser,
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [11:0] peak_to_peak, [27:12] busy_bin_total, [32:28] busy_bin_count,
  // [48:33] sets_seen, [55:49] zero
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] channel
  output      logic                   m_axis_tuser,
  output      logic                   m_axis_tlast,
  input  wire logic                   cfg_valid_i,
  output      logic                   cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CNT_W-1:0]       cfg_data_i
);

  localparam int unsigned BW = $clog2(BINS);
  localparam int unsigned AW = BW + 1;
  localparam int unsigned PW = SAMPLE_W + $clog2(BINS + 1);
  localparam int unsigned QW = PW - SAMPLE_W;
  localparam logic        LAST_CH  = 1'(CHANNELS - 1);
  localparam logic [BW-1:0] LAST_BIN = BW'(BINS - 1);

  appm_state_e state_q, state_d;

  logic                ch_q, ch_d;
  logic [BW-1:0]       bin_q, bin_d;
  logic [SAMPLE_W-1:0] samp0_q, samp1_q;
  logic [AW-1:0]       addr_q;
  logic [CNT_W-1:0]    min_sets_q, thr_q;
  logic [CNT_W-1:0]    set_cnt_q;
  logic [SAMPLE_W-1:0] max_q [CHANNELS];
  logic [SAMPLE_W-1:0] min_q [CHANNELS];

  logic [CNT_W-1:0]    mem [2**AW];
  logic [CNT_W-1:0]    rdata_q;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [CNT_W-1:0]    mem_wdata;

  logic                acc_en_q, acc_en_d;
  logic [CNT_W-1:0]    tot_q, tot_d;
  logic [BUSY_W-1:0]   cnt_q, cnt_d;
  logic                acc_clr;

  logic                out_vld_q;
  logic                out_ch_q, out_last_q;
  logic [SAMPLE_W-1:0] out_p2p_q;
  logic [CNT_W-1:0]    out_tot_q, out_sets_q;
  logic [BUSY_W-1:0]   out_cnt_q;

  logic                in_acc, load_go, stats_clr, minmax_upd, set_inc;
  logic [SAMPLE_W-1:0] samp_sel, max_sel, min_sel, p2p;
  logic [PW-1:0]       prod;
  logic [QW-1:0]       quot;
  logic [SAMPLE_W:0]   rem;
  logic [QW:0]         quot_fix;
  logic [BW-1:0]       bin_calc;
  logic [CNT_W:0]      sum;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign load_go = !out_vld_q || m_axis_tready;

  // Bin index: divide by 4095 as shift, add back quotient, one correction
  always_comb begin
    samp_sel = ch_q ? samp1_q : samp0_q;
    prod     = PW'(samp_sel) * PW'(BINS);
    quot     = prod[PW-1:SAMPLE_W];
    rem      = (SAMPLE_W+1)'(prod[SAMPLE_W-1:0]) + (SAMPLE_W+1)'(quot);
    quot_fix = (QW+1)'(quot) + ((rem >= (SAMPLE_W+1)'(ADC_FULL)) ? (QW+1)'(1) : '0);
    if (quot_fix > (QW+1)'(BINS - 1)) begin
      bin_calc = LAST_BIN;
    end else begin
      bin_calc = quot_fix[BW-1:0];
    end
  end

  always_comb begin
    max_sel = max_q[0];
    min_sel = min_q[0];
    for (int c = 0; c < CHANNELS; c++) begin
      if (ch_q == 1'(c)) begin
        max_sel = max_q[c];
        min_sel = min_q[c];
      end
    end
    p2p = (max_sel >= min_sel) ? max_sel - min_sel : '0;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (bin_q == LAST_BIN && ch_q == LAST_CH) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == CMD_SAMPLE) begin
            state_d = ST_RD;
          end else if (set_cnt_q > min_sets_q) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_RD: state_d = ST_WR;
      ST_WR: begin
        state_d = (ch_q == LAST_CH) ? ST_IDLE : ST_RD;
      end
      ST_SCAN: begin
        if (bin_q == LAST_BIN) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_LOAD;
      ST_LOAD: begin
        if (load_go) state_d = (ch_q == LAST_CH) ? ST_IDLE : ST_SCAN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = {ch_q, bin_q};
    mem_raddr  = {ch_q, bin_q};
    mem_wdata  = '0;
    minmax_upd = 1'b0;
    set_inc    = 1'b0;
    acc_en_d   = 1'b0;
    acc_clr    = 1'b0;
    stats_clr  = 1'b0;
    ch_d       = ch_q;
    bin_d      = bin_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        bin_d  = bin_q + BW'(1);
        if (bin_q == LAST_BIN) begin
          bin_d = '0;
          ch_d  = (ch_q == LAST_CH) ? 1'b0 : 1'b1;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ch_d  = 1'b0;
        bin_d = '0;
        acc_clr = 1'b1;
      end
      ST_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = {ch_q, bin_calc};
        minmax_upd = 1'b1;
      end
      ST_WR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = (rdata_q == CNT_MAX) ? rdata_q : rdata_q + CNT_W'(1);
        if (ch_q == LAST_CH) begin
          set_inc = 1'b1;
          ch_d    = 1'b0;
        end else begin
          ch_d = 1'b1;
        end
      end
      ST_SCAN: begin
        mem_re   = 1'b1;
        mem_we   = 1'b1;
        acc_en_d = 1'b1;
        bin_d    = (bin_q == LAST_BIN) ? '0 : bin_q + BW'(1);
      end
      ST_DRAIN: begin
      end
      ST_LOAD: begin
        if (load_go) begin
          acc_clr = 1'b1;
          if (ch_q == LAST_CH) begin
            stats_clr = 1'b1;
            ch_d      = 1'b0;
          end else begin
            ch_d = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      ch_q     <= 1'b0;
      bin_q    <= '0;
      acc_en_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ch_q     <= ch_d;
      bin_q    <= bin_d;
      acc_en_q <= acc_en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      samp0_q <= s_axis_tdata[SAMPLE_W-1:0];
      samp1_q <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
    end
    if (mem_re) begin
      addr_q <= mem_raddr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sets_q <= MIN_SETS_RST;
      thr_q      <= THRESHOLD_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_REPORT_MIN_SETS: min_sets_q <= cfg_data_i;
        REG_BIN_THRESHOLD:   thr_q      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_cnt_q <= '0;
    end else if (stats_clr) begin
      set_cnt_q <= '0;
    end else if (set_inc && set_cnt_q != CNT_MAX) begin
      set_cnt_q <= set_cnt_q + CNT_W'(1);
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_minmax
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        max_q[c] <= '0;
        min_q[c] <= ADC_FULL;
      end else if (stats_clr) begin
        max_q[c] <= '0;
        min_q[c] <= ADC_FULL;
      end else if (minmax_upd && ch_q == 1'(c)) begin
        if (samp_sel > max_q[c]) max_q[c] <= samp_sel;
        if (samp_sel < min_q[c]) min_q[c] <= samp_sel;
      end
    end
  end

  // Busy-bin accumulation, one bin per cycle behind the read
  always_comb begin
    tot_d = tot_q;
    cnt_d = cnt_q;
    sum   = (CNT_W+1)'(tot_q) + (CNT_W+1)'(rdata_q);
    if (acc_clr) begin
      tot_d = '0;
      cnt_d = '0;
    end else if (acc_en_q && rdata_q > thr_q) begin
      tot_d = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
      cnt_d = (cnt_q == BUSY_MAX) ? cnt_q : cnt_q + BUSY_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q <= '0;
      cnt_q <= '0;
    end else begin
      tot_q <= tot_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == ST_LOAD && load_go) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD && load_go) begin
      out_ch_q   <= ch_q;
      out_last_q <= (ch_q == LAST_CH);
      out_p2p_q  <= p2p;
      out_tot_q  <= tot_q;
      out_cnt_q  <= cnt_q;
      out_sets_q <= set_cnt_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_ch_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {7'b0, out_sets_q, out_cnt_q, out_tot_q, out_p2p_q};

  `APPM_ASSERT_STEP(a_report_skip,
    in_acc && s_axis_tuser == CMD_REPORT && set_cnt_q <= min_sets_q,
    state_q == ST_IDLE, "report tick below threshold started a report")
  `APPM_ASSERT_STEP(a_stats_clear, state_q == ST_LOAD && load_go && ch_q == LAST_CH,
    set_cnt_q == '0 && state_q == ST_IDLE, "statistics not cleared after report")
  `APPM_ASSERT_STEP(a_load_hold, state_q == ST_LOAD && out_vld_q && !m_axis_tready,
    state_q == ST_LOAD && out_vld_q, "report line loaded over a pending word")

endmodule

`default_nettype wire
